>>> src/bdc_pkg.sv
// shared types and constants for the button debounce / click / long press block
`timescale 1ns / 1ps

package bdc_pkg;

    // field widths
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int CNT_W  = 8;
    localparam int IDX_W  = 2;

    // register reset values in milliseconds
    localparam logic [CFG_W-1:0] DEBOUNCE_RST       = 16'd20;
    localparam logic [CFG_W-1:0] CLICK_INTERVAL_RST = 16'd250;
    localparam logic [CFG_W-1:0] LONG_THRESHOLD_RST = 16'd1000;
    localparam logic [CFG_W-1:0] LONG_TICK_RST      = 16'd100;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_DEBOUNCE       = 2'd0,
        CFG_CLICK_INTERVAL = 2'd1,
        CFG_LONG_THRESHOLD = 2'd2,
        CFG_LONG_TICK      = 2'd3
    } t_cfg_idx;

    // current register settings
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] click_interval_ms;
        logic [CFG_W-1:0] long_press_threshold_ms;
        logic [CFG_W-1:0] long_press_tick_ms;
    } t_cfg;

    // one result of a poll
    typedef struct packed {
        logic             stable_level;
        logic             press_event;
        logic             release_event;
        logic             long_press_event;
        logic [CNT_W-1:0] long_press_count;
        logic             click_event;
        logic [CNT_W-1:0] click_count;
    } t_result;

endpackage

>>> src/bdc_in_if.sv
// poll channel: raw pin level and millisecond timestamp
`timescale 1ns / 1ps

interface bdc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       pin_level;
    logic [bdc_pkg::TIME_W-1:0] time_ms;

    modport source (output valid, output pin_level, output time_ms, input ready);
    modport sink   (input valid, input pin_level, input time_ms, output ready);
endinterface

>>> src/bdc_out_if.sv
// result channel: debounced level and event flags
`timescale 1ns / 1ps

interface bdc_out_if;
    logic                      valid;
    logic                      ready;
    logic                      stable_level;
    logic                      press_event;
    logic                      release_event;
    logic                      long_press_event;
    logic [bdc_pkg::CNT_W-1:0] long_press_count;
    logic                      click_event;
    logic [bdc_pkg::CNT_W-1:0] click_count;

    modport source (
        output valid, output stable_level, output press_event, output release_event,
        output long_press_event, output long_press_count, output click_event,
        output click_count, input ready
    );
    modport sink (
        input valid, input stable_level, input press_event, input release_event,
        input long_press_event, input long_press_count, input click_event,
        input click_count, output ready
    );
endinterface

>>> src/bdc_cfg_regs.sv
// configuration register file with plain write port
`timescale 1ns / 1ps

module bdc_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bdc_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [bdc_pkg::CFG_W-1:0] i_cfg_data,
    output bdc_pkg::t_cfg             o_cfg
);

    bdc_pkg::t_cfg r_cfg;

    // register writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms             <= bdc_pkg::DEBOUNCE_RST;
            r_cfg.click_interval_ms       <= bdc_pkg::CLICK_INTERVAL_RST;
            r_cfg.long_press_threshold_ms <= bdc_pkg::LONG_THRESHOLD_RST;
            r_cfg.long_press_tick_ms      <= bdc_pkg::LONG_TICK_RST;
        end else if (i_cfg_we) begin
            case (bdc_pkg::t_cfg_idx'(i_cfg_idx))
                bdc_pkg::CFG_DEBOUNCE:       r_cfg.debounce_ms             <= i_cfg_data;
                bdc_pkg::CFG_CLICK_INTERVAL: r_cfg.click_interval_ms       <= i_cfg_data;
                bdc_pkg::CFG_LONG_THRESHOLD: r_cfg.long_press_threshold_ms <= i_cfg_data;
                bdc_pkg::CFG_LONG_TICK:      r_cfg.long_press_tick_ms      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/bdc_core.sv
// button state and single pass event logic for one poll
`timescale 1ns / 1ps

module bdc_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_level,
    input  logic [bdc_pkg::TIME_W-1:0] i_time,
    input  bdc_pkg::t_cfg              i_cfg,
    output bdc_pkg::t_result           o_res
);

    localparam int TW = bdc_pkg::TIME_W;
    localparam int CW = bdc_pkg::CNT_W;

    // button state
    logic          r_acc_level;
    logic          r_pending;
    logic [TW-1:0] r_pend_start;
    logic [TW-1:0] r_press_time;
    logic [TW-1:0] r_release_time;
    logic [CW-1:0] r_tick_count;
    logic [TW-1:0] r_last_tick;
    logic [CW-1:0] r_clicks;

    logic          n_acc_level;
    logic          n_pending;
    logic [TW-1:0] n_pend_start;
    logic [TW-1:0] n_press_time;
    logic [TW-1:0] n_release_time;
    logic [CW-1:0] n_tick_count;
    logic [TW-1:0] n_last_tick;
    logic [CW-1:0] n_clicks;

    logic          open_win;
    logic          pend_eff;
    logic [TW-1:0] d_pend;
    logic          expire;
    logic          take;
    logic          ev_press;
    logic          ev_release;
    logic [TW-1:0] d_press_old;
    logic [TW-1:0] d_press;
    logic          click_inc;
    logic [TW-1:0] d_tick;
    logic          ev_long;
    logic [CW-1:0] tick_base;
    logic [CW-1:0] clicks_after;
    logic [TW-1:0] d_release;
    logic          ev_click;

    // debounce window and level acceptance
    always_comb begin
        open_win     = (i_level != r_acc_level) && !r_pending;
        pend_eff     = r_pending || open_win;
        n_pend_start = open_win ? i_time : r_pend_start;
        d_pend       = open_win ? '0 : (i_time - r_pend_start);
        expire       = pend_eff && (d_pend >= {{(TW-bdc_pkg::CFG_W){1'b0}}, i_cfg.debounce_ms});
        n_pending    = pend_eff && !expire;
        take         = expire && (i_level != r_acc_level);
        n_acc_level  = take ? i_level : r_acc_level;
        ev_press     = take && i_level;
        ev_release   = take && !i_level;
        n_press_time   = ev_press ? i_time : r_press_time;
        n_release_time = ev_release ? i_time : r_release_time;
    end

    // click counting on a short release
    always_comb begin
        d_press_old  = i_time - r_press_time;
        click_inc    = ev_release &&
                       (d_press_old < {{(TW-bdc_pkg::CFG_W){1'b0}},
                                       i_cfg.long_press_threshold_ms});
        clicks_after = r_clicks + {{(CW-1){1'b0}}, click_inc};
    end

    // long press ticks
    always_comb begin
        d_press   = ev_press ? '0 : d_press_old;
        d_tick    = i_time - r_last_tick;
        ev_long   = n_acc_level &&
                    (d_press >= {{(TW-bdc_pkg::CFG_W){1'b0}}, i_cfg.long_press_threshold_ms}) &&
                    (d_tick >= {{(TW-bdc_pkg::CFG_W){1'b0}}, i_cfg.long_press_tick_ms});
        tick_base    = ev_release ? '0 : r_tick_count;
        n_tick_count = ev_long ? (tick_base + {{(CW-1){1'b0}}, 1'b1}) : tick_base;
        n_last_tick  = ev_long ? i_time : r_last_tick;
    end

    // click run report
    always_comb begin
        d_release = ev_release ? '0 : (i_time - r_release_time);
        ev_click  = !n_acc_level && (clicks_after != '0) &&
                    (d_release >= {{(TW-bdc_pkg::CFG_W){1'b0}}, i_cfg.click_interval_ms});
        n_clicks  = ev_click ? '0 : clicks_after;
    end

    // result of this poll
    always_comb begin
        o_res.stable_level     = n_acc_level;
        o_res.press_event      = ev_press;
        o_res.release_event    = ev_release;
        o_res.long_press_event = ev_long;
        o_res.long_press_count = n_tick_count;
        o_res.click_event      = ev_click;
        o_res.click_count      = ev_click ? clicks_after : '0;
    end

    // state update when a poll moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_level    <= 1'b0;
            r_pending      <= 1'b0;
            r_pend_start   <= '0;
            r_press_time   <= '0;
            r_release_time <= '0;
            r_tick_count   <= '0;
            r_last_tick    <= '0;
            r_clicks       <= '0;
        end else if (i_step) begin
            r_acc_level    <= n_acc_level;
            r_pending      <= n_pending;
            r_pend_start   <= n_pend_start;
            r_press_time   <= n_press_time;
            r_release_time <= n_release_time;
            r_tick_count   <= n_tick_count;
            r_last_tick    <= n_last_tick;
            r_clicks       <= n_clicks;
        end
    end

    // a click report never coincides with a held button
    a_click_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.click_event |-> !o_res.stable_level)
        else $error("click reported while button held");

    // a release always clears the tick counter
    a_release_clears_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.release_event |=> r_tick_count == '0)
        else $error("tick count not cleared on release");

    // the accepted level only moves together with an event
    a_level_with_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (n_acc_level != r_acc_level) |-> (ev_press || ev_release))
        else $error("level changed without press or release");

endmodule

>>> src/button_debounce_click_longpress.sv
// top level: input register, single pass poll logic, result register
// flow: a poll moves from the input register to the result register, which drives the outputs
// throughput: one poll per cycle; ready drops only while both registers hold and
//   the result is not taken
// reset: synchronous active low; registers return to their defaults, button state
//   and both pipeline valid flags clear, no clearing pass
`timescale 1ns / 1ps

module button_debounce_click_longpress (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bdc_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [bdc_pkg::CFG_W-1:0] i_cfg_data,
    bdc_in_if.sink                    i_in,
    bdc_out_if.source                 o_out
);

    bdc_pkg::t_cfg    cfg;
    bdc_pkg::t_result res;

    logic                       r_in_valid;
    logic                       r_in_level;
    logic [bdc_pkg::TIME_W-1:0] r_in_time;
    logic                       r_out_valid;
    bdc_pkg::t_result           r_out;
    logic                       advance;
    logic                       in_take;

    bdc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bdc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_level (r_in_level),
        .i_time  (r_in_time),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // pipeline flow control
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_level <= i_in.pin_level;
            r_in_time  <= i_in.time_ms;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    // result channel drive
    assign o_out.valid            = r_out_valid;
    assign o_out.stable_level     = r_out.stable_level;
    assign o_out.press_event      = r_out.press_event;
    assign o_out.release_event    = r_out.release_event;
    assign o_out.long_press_event = r_out.long_press_event;
    assign o_out.long_press_count = r_out.long_press_count;
    assign o_out.click_event      = r_out.click_event;
    assign o_out.click_count      = r_out.click_count;

    // press and release never reported in the same transaction
    a_press_xor_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.press_event && r_out.release_event))
        else $error("press and release in one transaction");

    // event flags agree with the reported level
    a_events_match_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.press_event || r_out.long_press_event)
        |-> r_out.stable_level)
        else $error("press or tick with released level");

    // a reported click run is never empty
    a_click_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.click_event == (r_out.click_count != '0)))
        else $error("click count disagrees with click event");

    // a poll held in the input register moves on when the result register is empty
    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_out_valid |=> r_out_valid)
        else $error("pipeline stalled with free result register");

endmodule

>>> tb/sv/tb_button_debounce_click_longpress.sv
// self-checking testbench for the button debounce, multi-click and long-press block
`timescale 1ns / 1ps

module tb_button_debounce_click_longpress;
    import bdc_pkg::*;

    localparam int unsigned RANDOM_POLLS = 1000;
    localparam int unsigned MAX_IDLE     = 17;
    localparam int unsigned HOLD_CYCLES  = 300;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    bdc_in_if  in_if ();
    bdc_out_if out_if ();

    button_debounce_click_longpress uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the registers and button state
    t_cfg             cfg;
    logic             btn_level;
    logic             btn_pending;
    logic [TIME_W-1:0] pend_start;
    logic [TIME_W-1:0] press_t;
    logic [TIME_W-1:0] release_t;
    logic [CNT_W-1:0]  tick_cnt;
    logic [TIME_W-1:0] last_tick_t;
    logic [CNT_W-1:0]  click_cnt;

    t_result          predicted_results[$];
    logic [TIME_W-1:0] now_ms;

    // handshake pacing controls
    bit               tx_idle_on;
    bit               rx_idle_on;
    int unsigned      rx_hold_req;

    // run statistics
    int unsigned      n_fail;
    int unsigned      n_polls;
    int unsigned      n_checked;
    int unsigned      n_settings;
    int unsigned      n_press;
    int unsigned      n_release;
    int unsigned      n_ticks;
    int unsigned      n_click_runs;
    int unsigned      max_run;

    function automatic t_cfg make_cfg(input int unsigned db, input int unsigned ci,
                                      input int unsigned th, input int unsigned tk);
        t_cfg s;
        s.debounce_ms             = CFG_W'(db);
        s.click_interval_ms       = CFG_W'(ci);
        s.long_press_threshold_ms = CFG_W'(th);
        s.long_press_tick_ms      = CFG_W'(tk);
        return s;
    endfunction

    function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
                                                  input logic [TIME_W-1:0] since);
        return now - since;
    endfunction

    // button state after reset
    task automatic clear_button_state();
        cfg         = make_cfg(DEBOUNCE_RST, CLICK_INTERVAL_RST, LONG_THRESHOLD_RST,
                               LONG_TICK_RST);
        btn_level   = 1'b0;
        btn_pending = 1'b0;
        pend_start  = '0;
        press_t     = '0;
        release_t   = '0;
        tick_cnt    = '0;
        last_tick_t = '0;
        click_cnt   = '0;
    endtask

    // expected result of one poll, advancing the predicted state
    function automatic t_result predict_poll(input logic level,
                                             input logic [TIME_W-1:0] now);
        t_result r;
        r = '0;
        // debounce window
        if (level != btn_level && !btn_pending) begin
            btn_pending = 1'b1;
            pend_start  = now;
        end
        if (btn_pending && elapsed(now, pend_start) >= TIME_W'(cfg.debounce_ms)) begin
            btn_pending = 1'b0;
            if (level != btn_level) begin
                btn_level = level;
                if (level) begin
                    press_t       = now;
                    r.press_event = 1'b1;
                end else begin
                    release_t       = now;
                    r.release_event = 1'b1;
                    if (elapsed(now, press_t) < TIME_W'(cfg.long_press_threshold_ms))
                        click_cnt = click_cnt + 1'b1;
                    tick_cnt = '0;
                end
            end
        end
        // long-press ticks
        if (btn_level &&
            elapsed(now, press_t) >= TIME_W'(cfg.long_press_threshold_ms) &&
            elapsed(now, last_tick_t) >= TIME_W'(cfg.long_press_tick_ms)) begin
            tick_cnt           = tick_cnt + 1'b1;
            last_tick_t        = now;
            r.long_press_event = 1'b1;
        end
        // click run report
        if (!btn_level && click_cnt != '0 &&
            elapsed(now, release_t) >= TIME_W'(cfg.click_interval_ms)) begin
            r.click_event = 1'b1;
            r.click_count = click_cnt;
            click_cnt     = '0;
        end
        r.stable_level     = btn_level;
        r.long_press_count = tick_cnt;
        return r;
    endfunction

    // one poll transaction, then the idle gap drawn for it
    task automatic send_poll(input logic level, input logic [TIME_W-1:0] stamp);
        t_result     r;
        int unsigned gap;
        in_if.valid     <= 1'b1;
        in_if.pin_level <= level;
        in_if.time_ms   <= stamp;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        r = predict_poll(level, stamp);
        predicted_results.push_back(r);
        n_polls++;
        n_press   += r.press_event;
        n_release += r.release_event;
        n_ticks   += r.long_press_event;
        if (r.click_event) begin
            n_click_runs++;
            if (r.click_count > max_run)
                max_run = r.click_count;
        end
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic poll(input logic level, input int unsigned dt);
        now_ms = now_ms + dt;
        send_poll(level, now_ms);
    endtask

    // several polls of one level spread over roughly dur milliseconds
    task automatic hold_level(input logic level, input int unsigned dur,
                              input int unsigned n);
        for (int k = 0; k < n; k++)
            poll(level, $urandom_range(0, 2 * (dur / n) + 1));
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write all four registers, block idle
    task automatic apply_settings(input t_cfg s);
        t_cfg_idx         idx;
        logic [CFG_W-1:0] val;
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_idx'(k);
            case (idx)
                CFG_DEBOUNCE:       val = s.debounce_ms;
                CFG_CLICK_INTERVAL: val = s.click_interval_ms;
                CFG_LONG_THRESHOLD: val = s.long_press_threshold_ms;
                default:            val = s.long_press_tick_ms;
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= val;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg = s;
        n_settings++;
    endtask

    // reset values, bounce back, press, ticks, click report, zero debounce, time wrap
    task automatic test_directed();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_poll(1'b0, 32'd0);
        send_poll(1'b1, 32'd5);
        send_poll(1'b0, 32'd10);
        send_poll(1'b0, 32'd30);
        send_poll(1'b1, 32'd40);
        send_poll(1'b1, 32'd60);
        send_poll(1'b1, 32'd1060);
        send_poll(1'b1, 32'd1100);
        send_poll(1'b1, 32'd1160);
        send_poll(1'b0, 32'd1170);
        send_poll(1'b0, 32'd1190);
        send_poll(1'b1, 32'd1200);
        send_poll(1'b1, 32'd1220);
        send_poll(1'b0, 32'd1300);
        send_poll(1'b0, 32'd1320);
        send_poll(1'b0, 32'd1570);
        wait_drain();
        // zero debounce across the timestamp wrap, backward jump reads as long quiet
        apply_settings(make_cfg(0, 16'hFFFF, 16'hFFFF, 0));
        send_poll(1'b1, 32'hFFFF_FFF0);
        send_poll(1'b0, 32'h0000_0010);
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b1, 32'd0);
        wait_drain();
        // everything zero: tick on every held poll, no click
        apply_settings(make_cfg(0, 0, 0, 0));
        send_poll(1'b1, 32'd0);
        send_poll(1'b1, 32'd0);
        send_poll(1'b0, 32'd3);
        send_poll(1'b0, 32'd3);
        wait_drain();
        now_ms = 32'd3;
    endtask

    // 256 clicks wrap the click counter to zero, so the run goes unreported
    task automatic test_click_wrap();
        apply_settings(make_cfg(0, 16'hFFFF, 16'hFFFF, $urandom_range(0, 65535)));
        for (int k = 0; k < 256; k++) begin
            poll(1'b1, $urandom_range(1, 50));
            poll(1'b0, $urandom_range(1, 50));
        end
        poll(1'b0, 70000);
        for (int k = 0; k < 3; k++) begin
            poll(1'b1, $urandom_range(1, 50));
            poll(1'b0, $urandom_range(1, 50));
        end
        poll(1'b0, 65535);
        wait_drain();
    endtask

    // hold long enough for the tick counter to wrap
    task automatic test_tick_wrap();
        int unsigned start;
        apply_settings(make_cfg($urandom_range(0, 3), 10, 0, 1));
        hold_level(1'b1, 8, 2);
        start = n_ticks;
        while (n_ticks - start < 262)
            poll(1'b1, $urandom_range(0, 4));
        hold_level(1'b0, 20, 3);
        wait_drain();
    endtask

    // receiver stalls long while polls keep coming, then a full drain mid-stream
    task automatic test_backpressure();
        apply_settings(make_cfg(2, 30, 40, 5));
        tx_idle_on  = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        for (int k = 0; k < 40; k++)
            poll(1'($urandom_range(0, 1)), $urandom_range(0, 12));
        wait_drain();
        for (int k = 0; k < 20; k++)
            poll(1'($urandom_range(0, 1)), $urandom_range(0, 12));
        wait_drain();
        tx_idle_on = 1'b1;
    endtask

    // one random button gesture scaled to the current settings
    task automatic random_gesture();
        int unsigned db;
        int unsigned ci;
        int unsigned th;
        int unsigned tk;
        int unsigned pick;
        logic        lvl;
        db   = cfg.debounce_ms;
        ci   = cfg.click_interval_ms;
        th   = cfg.long_press_threshold_ms;
        tk   = cfg.long_press_tick_ms;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // short press and release, often part of a multi-click run
            hold_level(1'b1, db + $urandom_range(0, th), $urandom_range(2, 4));
            hold_level(1'b0, db + $urandom_range(0, ci / 2 + 1), $urandom_range(2, 3));
        end else if (pick < 50) begin
            // long press with repeated ticks
            hold_level(1'b1, db + th + $urandom_range(0, 6 * tk + 6), $urandom_range(4, 12));
            hold_level(1'b0, db + 1, 2);
        end else if (pick < 65) begin
            // contact bounce inside the debounce window
            lvl = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 4)) begin
                poll(lvl, $urandom_range(0, db));
                lvl = !lvl;
            end
        end else if (pick < 80) begin
            // quiet released stretch so a click run gets reported
            hold_level(1'b0, ci + $urandom_range(0, ci + 2), $urandom_range(1, 3));
        end else if (pick < 95) begin
            // noise
            repeat ($urandom_range(1, 3))
                poll(1'($urandom_range(0, 1)), $urandom_range(0, 2 * db + 2));
            if ($urandom_range(0, 3) == 0)
                poll(1'($urandom_range(0, 1)), $urandom());
        end else begin
            // timestamp jumps anywhere, backwards too
            now_ms = $urandom();
            poll(1'($urandom_range(0, 1)), 0);
        end
    endtask

    // random gestures over a series of register settings
    task automatic test_random();
        int unsigned start;
        int unsigned phase;
        int unsigned pick;
        t_cfg        s;
        start = n_polls;
        phase = 0;
        while (n_polls - start < RANDOM_POLLS) begin
            pick = (phase < 6) ? phase : $urandom_range(0, 5);
            case (pick)
                0: s = make_cfg(DEBOUNCE_RST, CLICK_INTERVAL_RST, LONG_THRESHOLD_RST,
                                LONG_TICK_RST);
                1: s = make_cfg($urandom_range(0, 4), $urandom_range(1, 20),
                                $urandom_range(5, 40), $urandom_range(0, 8));
                2: s = make_cfg(0, 0, 0, 0);
                3: s = make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                4: s = make_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), $urandom_range(0, 65535));
                default: s = make_cfg(0, $urandom_range(0, 30), $urandom_range(0, 60),
                                      $urandom_range(0, 10));
            endcase
            apply_settings(s);
            // one phase runs with no idling on either side
            tx_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
            repeat (30) begin
                if (n_polls - start < RANDOM_POLLS)
                    random_gesture();
            end
            wait_drain();
            phase++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // result receiver with random stalls and requested long hold-offs
    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall       = rx_hold_req;
            rx_hold_req = 0;
            if (stall == 0 && rx_idle_on)
                stall = $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (predicted_results.size() == 0) begin
                $error("result transaction with no poll outstanding");
                n_fail++;
            end else begin
                want = predicted_results.pop_front();
                n_checked++;
                check_field("stable_level", want.stable_level, out_if.stable_level);
                check_field("press_event", want.press_event, out_if.press_event);
                check_field("release_event", want.release_event, out_if.release_event);
                check_field("long_press_event", want.long_press_event,
                            out_if.long_press_event);
                check_field("long_press_count", want.long_press_count,
                            out_if.long_press_count);
                check_field("click_event", want.click_event, out_if.click_event);
                check_field("click_count", want.click_count, out_if.click_count);
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_DEBOUNCE;
        i_cfg_data      <= '0;
        in_if.valid     <= 1'b0;
        in_if.pin_level <= 1'b0;
        in_if.time_ms   <= '0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        rx_hold_req     = 0;
        n_fail          = 0;
        n_polls         = 0;
        n_checked       = 0;
        n_settings      = 0;
        n_press         = 0;
        n_release       = 0;
        n_ticks         = 0;
        n_click_runs    = 0;
        max_run         = 0;
        now_ms          = '0;
        clear_button_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_click_wrap();
        test_tick_wrap();
        test_backpressure();
        test_random();

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (predicted_results.size() != 0) begin
            $error("%0d predicted results never arrived", predicted_results.size());
            n_fail++;
        end
        $display("covered %0d polls under %0d register settings: %0d presses, %0d releases",
                 n_polls, n_settings, n_press, n_release);
        $display("%0d long-press ticks, %0d click runs (largest %0d), %0d results checked",
                 n_ticks, n_click_runs, max_run, n_checked);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("watchdog expired with %0d results outstanding", predicted_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
